### hdl/kwslm_pkg.sv
// ----------------------------------------------------------------------------
// kwslm_pkg
// Shared types, constants and control bundles for the k-way sorted list merge.
// ----------------------------------------------------------------------------
package kwslm_pkg;

	// Default sizes of the list store.
	localparam int NUM_LISTS_DEF  = 14;
	localparam int LIST_DEPTH_DEF = 16;

	// Fixed payload widths.
	localparam int DIST_W = 31;
	localparam int ID_W   = 32;
	localparam int LIDX_W = 4;
	localparam int POS_W  = 4;
	localparam int SLOT_W = 4;

	// Largest finite single-precision value, as raw bits.
	localparam logic [DIST_W-1:0] MAX_FINITE = 31'h7F7F_FFFF;

	// Request kinds.
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_MERGE = 1'b1;

	// One stored list entry.
	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic [ID_W-1:0]   id;
	} ent_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_we;
		logic merge_init;
		logic scan_step;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_done;
		logic slot_zero;
		logic out_busy;
	} sts_t;

endpackage

### hdl/kwslm_ctrl.sv
// ----------------------------------------------------------------------------
// kwslm_ctrl
// Controller state machine: takes requests, sequences head scans and results.
// ----------------------------------------------------------------------------
module kwslm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              kind,
	input  kwslm_pkg::sts_t   sts,
	output kwslm_pkg::cmd_t   cmd
);
	import kwslm_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands.
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (kind == KIND_MERGE) begin
						cmd.merge_init = 1'b1;
						state_nxt      = ST_SCAN;
					end else begin
						cmd.load_we = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				// The result leaves only once the output register can take it.
				if (!sts.out_busy) begin
					cmd.emit  = 1'b1;
					state_nxt = sts.slot_zero ? ST_IDLE : ST_SCAN;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

### hdl/kwslm_dpath.sv
// ----------------------------------------------------------------------------
// kwslm_dpath
// Datapath: list entry memory, read pointers, minimum search and output register.
// ----------------------------------------------------------------------------
module kwslm_dpath #(
	parameter int NUM_LISTS  = kwslm_pkg::NUM_LISTS_DEF,
	parameter int LIST_DEPTH = kwslm_pkg::LIST_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  kwslm_pkg::cmd_t                cmd,
	output kwslm_pkg::sts_t                sts,
	input  logic [kwslm_pkg::LIDX_W-1:0]   list_index,
	input  logic [kwslm_pkg::POS_W-1:0]    position,
	input  logic [kwslm_pkg::DIST_W-1:0]   distance_bits,
	input  logic [kwslm_pkg::ID_W-1:0]     point_id,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [kwslm_pkg::SLOT_W-1:0]   slot,
	output logic [kwslm_pkg::DIST_W-1:0]   distance_bits_res,
	output logic [kwslm_pkg::ID_W-1:0]     point_id_res,
	output logic                           last
);
	import kwslm_pkg::*;

	localparam int LW = $clog2(NUM_LISTS);
	localparam int CW = $clog2(NUM_LISTS + 1);
	localparam int RW = $clog2(LIST_DEPTH + 1);
	localparam int PW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int NE = NUM_LISTS * LIST_DEPTH;
	localparam int AW = (NE > 1) ? $clog2(NE) : 1;

	localparam logic [AW-1:0] DEPTH_A   = AW'(LIST_DEPTH);
	localparam logic [CW-1:0] NLISTS_C  = CW'(NUM_LISTS);
	localparam logic [RW-1:0] DEPTH_R   = RW'(LIST_DEPTH);
	localparam logic [PW-1:0] TOP_SLOT  = PW'(LIST_DEPTH - 1);

	ent_t           mem [NE];
	ent_t           rd_ent_s1;
	logic           rd_vld_s1;
	logic [LW-1:0]  rd_list_s1;

	logic [RW-1:0]  rem_q [NUM_LISTS];
	logic [CW-1:0]  scan_cnt_q;
	logic [PW-1:0]  slot_q;

	logic [DIST_W-1:0] best_dist_q;
	logic [LW-1:0]     best_list_q;
	logic              found_q;

	logic              out_valid_q;
	logic [PW-1:0]     out_slot_q;
	logic [DIST_W-1:0] out_dist_q;
	logic [ID_W-1:0]   out_id_q;
	logic              out_last_q;

	logic              scan_live;
	logic [LW-1:0]     scan_list;
	logic [RW-1:0]     scan_rem;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     wr_addr;
	logic              wr_ok;
	logic [PW+SLOT_W-1:0] slot_wide;

	// Read address of the head of the list under scan.
	always_comb begin
		scan_live = (scan_cnt_q < NLISTS_C);
		scan_list = scan_live ? scan_cnt_q[LW-1:0] : '0;
		scan_rem  = rem_q[scan_list];
		rd_addr   = AW'(scan_list) * DEPTH_A + AW'(scan_rem - RW'(1));
	end

	// Write address of a loaded entry; out-of-range loads are dropped.
	always_comb begin
		wr_ok   = (32'(list_index) < NUM_LISTS) && (32'(position) < LIST_DEPTH);
		wr_addr = AW'(list_index) * DEPTH_A + AW'(position);
	end

	// Entry memory with a registered read port.
	always_ff @(posedge clk) begin
		if (cmd.load_we && wr_ok) begin
			mem[wr_addr] <= '{distance: distance_bits, id: point_id};
		end
		rd_ent_s1 <= mem[rd_addr];
	end

	// Scan pipeline control: one list head read per step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q <= '0;
			rd_vld_s1  <= 1'b0;
			rd_list_s1 <= '0;
		end else begin
			rd_vld_s1  <= cmd.scan_step && scan_live && (scan_rem != '0);
			rd_list_s1 <= scan_list;
			if (cmd.merge_init || cmd.emit) begin
				scan_cnt_q <= '0;
			end else if (cmd.scan_step && scan_live) begin
				scan_cnt_q <= scan_cnt_q + CW'(1);
			end
		end
	end

	// Running minimum over the heads; ties keep the earlier (lower) list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_dist_q <= MAX_FINITE;
			best_list_q <= '0;
			found_q     <= 1'b0;
		end else if (cmd.merge_init || cmd.emit) begin
			best_dist_q <= MAX_FINITE;
			best_list_q <= '0;
			found_q     <= 1'b0;
		end else if (rd_vld_s1 && (rd_ent_s1.distance < best_dist_q)) begin
			best_dist_q <= rd_ent_s1.distance;
			best_list_q <= rd_list_s1;
			found_q     <= 1'b1;
		end
	end

	// Identifier of the current best head, captured alongside the distance.
	logic [ID_W-1:0] best_id_q;
	always_ff @(posedge clk) begin
		if (cmd.merge_init || cmd.emit) begin
			best_id_q <= '0;
		end else if (rd_vld_s1 && (rd_ent_s1.distance < best_dist_q)) begin
			best_id_q <= rd_ent_s1.id;
		end
	end

	// Remaining entries per list; the winning list steps down on emit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NUM_LISTS; j++) begin
				rem_q[j] <= DEPTH_R;
			end
		end else begin
			for (int j = 0; j < NUM_LISTS; j++) begin
				if (cmd.merge_init) begin
					rem_q[j] <= DEPTH_R;
				end else if (cmd.emit && found_q && (best_list_q == LW'(j))) begin
					rem_q[j] <= rem_q[j] - RW'(1);
				end
			end
		end
	end

	// Slot counter, counting down from the top of the global list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= TOP_SLOT;
		end else if (cmd.merge_init) begin
			slot_q <= TOP_SLOT;
		end else if (cmd.emit) begin
			slot_q <= slot_q - PW'(1);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_slot_q <= slot_q;
			out_dist_q <= best_dist_q;
			out_id_q   <= best_id_q;
			out_last_q <= (slot_q == '0);
		end
	end

	// Status back to the controller.
	always_comb begin
		sts.scan_done = !scan_live;
		sts.slot_zero = (slot_q == '0);
		sts.out_busy  = out_valid_q && !out_ready;
	end

	// Result ports; the slot is cut to its port width.
	assign slot_wide         = (PW + SLOT_W)'(out_slot_q);
	assign slot              = slot_wide[SLOT_W-1:0];
	assign out_valid         = out_valid_q;
	assign distance_bits_res = out_dist_q;
	assign point_id_res      = out_id_q;
	assign last              = out_last_q;

endmodule

### hdl/k_way_sorted_list_merge.sv
// ----------------------------------------------------------------------------
// k_way_sorted_list_merge
// Merges NUM_LISTS sorted partial lists into one global list of LIST_DEPTH.
// ----------------------------------------------------------------------------
// A load request is accepted while idle and writes one entry into the list
// memory, unless its list index or position is out of range. A merge request
// then produces LIST_DEPTH results, slot LIST_DEPTH-1 first and slot 0
// (flagged by last) at the end. For each result the single read port of the
// entry memory visits one list head per cycle, a further scan step drains the
// read pipeline, and the emit state hands the pick to the output register,
// waiting while the output is stalled. The next request is taken right after
// the final result enters the output register.
module k_way_sorted_list_merge #(
	parameter int NUM_LISTS  = kwslm_pkg::NUM_LISTS_DEF,
	parameter int LIST_DEPTH = kwslm_pkg::LIST_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           kind,
	input  logic [kwslm_pkg::LIDX_W-1:0]   list_index,
	input  logic [kwslm_pkg::POS_W-1:0]    position,
	input  logic [kwslm_pkg::DIST_W-1:0]   distance_bits,
	input  logic [kwslm_pkg::ID_W-1:0]     point_id,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [kwslm_pkg::SLOT_W-1:0]   slot,
	output logic [kwslm_pkg::DIST_W-1:0]   distance_bits_res,
	output logic [kwslm_pkg::ID_W-1:0]     point_id_res,
	output logic                           last
);
	import kwslm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Controller.
	kwslm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath.
	kwslm_dpath #(
		.NUM_LISTS  (NUM_LISTS),
		.LIST_DEPTH (LIST_DEPTH)
	) u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.list_index        (list_index),
		.position          (position),
		.distance_bits     (distance_bits),
		.point_id          (point_id),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.slot              (slot),
		.distance_bits_res (distance_bits_res),
		.point_id_res      (point_id_res),
		.last              (last)
	);

endmodule
